// File: src/lbca_pkg.sv
// Shared types and constants of the linked block chain allocator.
// Used by every module of the block; depends on nothing.
package lbca_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned OPCODE_W  = 1;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned COUNT_W   = 9;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned FIRST_W   = 8;

  // Configuration port layout.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned SLOTS_REG_W = 5;

  // Highest slot count that a request can name.
  localparam int unsigned MAX_SLOTS = 2 ** SLOT_W;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE  = 2'd1;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0]  BLOCKS_RESET = 9'd256;
  localparam logic [SLOTS_REG_W-1:0] SLOTS_RESET  = 5'd16;

  // Request opcodes.
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_SLOT_BUSY  = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_SLOT_EMPTY = 3'd3,
    ST_ZERO_COUNT = 3'd4
  } status_e;

  // Strobes from the sequencer to the block table memories.
  typedef struct packed {
    logic rd_en;
    logic used_we;
    logic used_wd;
    logic next_we;
  } mem_ctl_t;

endpackage

// File: src/lbca_mem.sv
// Block table storage: the used mark and the next pointer of every block.
// One write port per array and one shared registered read port; uses lbca_pkg.
module lbca_mem #(
  parameter int unsigned NUM_BLOCKS = 256
) (
  input  logic                          clk_i,
  input  lbca_pkg::mem_ctl_t            ctl_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] rd_addr_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] used_addr_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] next_addr_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0] next_data_i,
  output logic                          used_rd_o,
  output logic [$clog2(NUM_BLOCKS)-1:0] next_rd_o
);

  localparam int unsigned BW = $clog2(NUM_BLOCKS);

  logic          used_mem [NUM_BLOCKS];
  logic [BW-1:0] next_mem [NUM_BLOCKS];
  logic          used_rd_q;
  logic [BW-1:0] next_rd_q;

  // Used marks: written by the clearing pass, the scan and the chain walk.
  always_ff @(posedge clk_i) begin
    if (ctl_i.used_we) begin
      used_mem[used_addr_i] <= ctl_i.used_wd;
    end
    if (ctl_i.rd_en) begin
      used_rd_q <= used_mem[rd_addr_i];
    end
  end

  // Next pointers: written while a chain is built.
  always_ff @(posedge clk_i) begin
    if (ctl_i.next_we) begin
      next_mem[next_addr_i] <= next_data_i;
    end
    if (ctl_i.rd_en) begin
      next_rd_q <= next_mem[rd_addr_i];
    end
  end

  assign used_rd_o = used_rd_q;
  assign next_rd_o = next_rd_q;

endmodule

// File: src/lbca_ctrl.sv
// Sequencer of the allocator: slot table, free counter, block scan and chain walk.
// Drives the block table in lbca_mem and holds the result register; uses lbca_pkg.
module lbca_ctrl #(
  parameter int unsigned NUM_BLOCKS = 256,
  parameter int unsigned NUM_SLOTS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                clear_req_i,
  input  logic [lbca_pkg::CFG_DATA_W-1:0]     blocks_in_use_i,
  input  logic [lbca_pkg::SLOTS_REG_W-1:0]    slots_in_use_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbca_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [lbca_pkg::SLOT_W-1:0]         file_slot_i,
  input  logic [lbca_pkg::COUNT_W-1:0]        block_count_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lbca_pkg::STATUS_W-1:0]       status_o,
  output logic [lbca_pkg::FIRST_W-1:0]        first_block_o,
  output logic [lbca_pkg::COUNT_W-1:0]        blocks_moved_o,
  output logic [lbca_pkg::COUNT_W-1:0]        free_left_o,
  output lbca_pkg::mem_ctl_t                  mem_ctl_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       rd_addr_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       used_addr_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       next_addr_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]       next_data_o,
  input  logic                                used_rd_i,
  input  logic [$clog2(NUM_BLOCKS)-1:0]       next_rd_i
);

  localparam int unsigned BW  = $clog2(NUM_BLOCKS);
  localparam int unsigned CW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned NS  = (NUM_SLOTS < lbca_pkg::MAX_SLOTS) ? NUM_SLOTS
                                                                  : lbca_pkg::MAX_SLOTS;
  localparam int unsigned SIW = (NS > 1) ? $clog2(NS) : 1;
  localparam int unsigned KW  = lbca_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_LINK,
    S_WALK_RD,
    S_WALK,
    S_DONE
  } state_e;

  state_e                     state_q, state_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic                       pend_q, pend_d;
  logic [BW-1:0]              pidx_q, pidx_d;
  logic [KW-1:0]              cnt_q, cnt_d;
  logic [KW-1:0]              want_q, want_d;
  logic [SIW-1:0]             slot_q, slot_d;
  logic [BW-1:0]              head_q, head_d;
  logic [BW-1:0]              prev_q, prev_d;
  logic [BW-1:0]              cur_q, cur_d;
  logic [CW-1:0]              steps_q, steps_d;
  logic [KW-1:0]              free_q, free_d;
  logic [NS-1:0]              slot_valid_q, slot_valid_d;
  logic [BW-1:0]              slot_head_q [NS];
  logic                       head_we;
  lbca_pkg::status_e          res_st_q, res_st_d;
  logic [BW-1:0]              res_head_q, res_head_d;
  logic [KW-1:0]              res_moved_q, res_moved_d;
  logic [KW-1:0]              res_free_q, res_free_d;
  logic                       out_valid_q, out_valid_d;
  logic [lbca_pkg::STATUS_W-1:0] out_st_q, out_st_d;
  logic [BW-1:0]              out_head_q, out_head_d;
  logic [KW-1:0]              out_moved_q, out_moved_d;
  logic [KW-1:0]              out_free_q, out_free_d;

  logic [CW-1:0]              blk_lim;
  logic                       slot_oor;
  logic [SIW-1:0]             slot_idx;
  logic                       issue;
  logic [KW-1:0]              moved;
  logic                       walk_end;

  // Effective limits: the registers saturate at the table sizes.
  always_comb begin
    if (32'(blocks_in_use_i) < NUM_BLOCKS) begin
      blk_lim = CW'(blocks_in_use_i);
    end else begin
      blk_lim = CW'(NUM_BLOCKS);
    end
  end

  assign slot_oor = (32'(file_slot_i) >= 32'(slots_in_use_i)) || (32'(file_slot_i) >= NS);
  assign slot_idx = file_slot_i[SIW-1:0];
  assign issue    = (idx_q < blk_lim);
  assign moved    = cnt_q + KW'(used_rd_i);
  assign walk_end = (next_rd_i == cur_q) || (steps_q == CW'(NUM_BLOCKS - 1));

  // Sequencer: next state, table writes and result capture.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    cnt_d        = cnt_q;
    want_d       = want_q;
    slot_d       = slot_q;
    head_d       = head_q;
    prev_d       = prev_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    free_d       = free_q;
    slot_valid_d = slot_valid_q;
    head_we      = 1'b0;
    res_st_d     = res_st_q;
    res_head_d   = res_head_q;
    res_moved_d  = res_moved_q;
    res_free_d   = res_free_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_st_d     = out_st_q;
    out_head_d   = out_head_q;
    out_moved_d  = out_moved_q;
    out_free_d   = out_free_q;
    mem_ctl_o    = '0;
    rd_addr_o    = idx_q[BW-1:0];
    used_addr_o  = pidx_q;
    next_addr_o  = prev_q;
    next_data_o  = pidx_q;

    case (state_q)
      // Clearing pass: one block per cycle over the whole table.
      S_CLEAR: begin
        mem_ctl_o.used_we = 1'b1;
        mem_ctl_o.used_wd = 1'b0;
        used_addr_o       = idx_q[BW-1:0];
        if (idx_q == CW'(NUM_BLOCKS - 1)) begin
          free_d  = KW'(blk_lim);
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // Request checks; errors go straight to the result.
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d      = slot_idx;
          res_head_d  = '0;
          res_moved_d = '0;
          res_free_d  = free_q;
          state_d     = S_DONE;
          if (slot_oor) begin
            res_st_d = lbca_pkg::ST_SLOT_BUSY;
          end else if (opcode_i == lbca_pkg::OP_ALLOC) begin
            if (slot_valid_q[slot_idx]) begin
              res_st_d = lbca_pkg::ST_SLOT_BUSY;
            end else if (block_count_i == '0) begin
              res_st_d = lbca_pkg::ST_ZERO_COUNT;
            end else if (block_count_i > free_q) begin
              res_st_d = lbca_pkg::ST_NO_SPACE;
            end else begin
              idx_d   = '0;
              pend_d  = 1'b0;
              cnt_d   = '0;
              head_d  = '0;
              prev_d  = '0;
              want_d  = block_count_i;
              state_d = S_SCAN;
            end
          end else begin
            if (!slot_valid_q[slot_idx]) begin
              res_st_d = lbca_pkg::ST_SLOT_EMPTY;
            end else begin
              head_d  = slot_head_q[slot_idx];
              cur_d   = slot_head_q[slot_idx];
              cnt_d   = '0;
              steps_d = '0;
              state_d = S_WALK_RD;
            end
          end
        end
      end

      // First-fit scan: read one block per cycle, claim it in the cycle after its read.
      S_SCAN: begin
        mem_ctl_o.rd_en = issue;
        pend_d          = issue;
        pidx_d          = idx_q[BW-1:0];
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (pend_q) begin
          if (!used_rd_i) begin
            mem_ctl_o.used_we = 1'b1;
            mem_ctl_o.used_wd = 1'b1;
            if (cnt_q == '0) begin
              head_d = pidx_q;
            end else begin
              mem_ctl_o.next_we = 1'b1;
            end
            prev_d = pidx_q;
            cnt_d  = cnt_q + 1'b1;
            if (cnt_q + 1'b1 == want_q) begin
              state_d = S_LINK;
            end
          end
        end else if (!issue) begin
          state_d = S_LINK;
        end
      end

      // Close the chain on its last block and record the slot.
      S_LINK: begin
        mem_ctl_o.next_we        = 1'b1;
        next_addr_o              = prev_q;
        next_data_o              = prev_q;
        slot_valid_d[slot_q]     = 1'b1;
        head_we                  = 1'b1;
        free_d                   = free_q - cnt_q;
        res_st_d                 = lbca_pkg::ST_OK;
        res_head_d               = head_q;
        res_moved_d              = cnt_q;
        res_free_d               = free_q - cnt_q;
        state_d                  = S_DONE;
      end

      // Fetch the head block of the chain.
      S_WALK_RD: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = cur_q;
        state_d         = S_WALK;
      end

      // Chain walk: free the current block and fetch its successor.
      S_WALK: begin
        used_addr_o = cur_q;
        if (used_rd_i) begin
          mem_ctl_o.used_we = 1'b1;
          mem_ctl_o.used_wd = 1'b0;
        end
        cnt_d   = moved;
        steps_d = steps_q + 1'b1;
        if (walk_end) begin
          slot_valid_d[slot_q] = 1'b0;
          free_d               = free_q + moved;
          res_st_d             = lbca_pkg::ST_OK;
          res_head_d           = head_q;
          res_moved_d          = moved;
          res_free_d           = free_q + moved;
          state_d              = S_DONE;
        end else begin
          mem_ctl_o.rd_en = 1'b1;
          rd_addr_o       = next_rd_i;
          cur_d           = next_rd_i;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_head_d  = res_head_q;
          out_moved_d = res_moved_q;
          out_free_d  = res_free_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_CLEAR;
        idx_d   = '0;
      end
    endcase

    // A register write restarts the clearing pass.
    if (clear_req_i) begin
      state_d      = S_CLEAR;
      idx_d        = '0;
      slot_valid_d = '0;
    end
  end

  // State, control and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      cnt_q        <= '0;
      free_q       <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      pend_q       <= pend_d;
      cnt_q        <= cnt_d;
      free_q       <= free_d;
      slot_valid_q <= slot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q      <= pidx_d;
    want_q      <= want_d;
    slot_q      <= slot_d;
    head_q      <= head_d;
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    steps_q     <= steps_d;
    res_st_q    <= res_st_d;
    res_head_q  <= res_head_d;
    res_moved_q <= res_moved_d;
    res_free_q  <= res_free_d;
    out_st_q    <= out_st_d;
    out_head_q  <= out_head_d;
    out_moved_q <= out_moved_d;
    out_free_q  <= out_free_d;
    if (head_we) begin
      slot_head_q[slot_q] <= head_q;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign first_block_o  = lbca_pkg::FIRST_W'(out_head_q);
  assign blocks_moved_o = out_moved_q;
  assign free_left_o    = out_free_q;

endmodule

// File: src/linked_block_chain_allocator_unit.sv
// A rejected request skips the table work and goes straight to the result. An allocate
// scans the block table from the start, reading one used mark per cycle, up to the last
// block it claims; a free fetches the head block and walks the chain to its tail.
// Throughput: one request at a time; the next is accepted from the cycle after the result
// is registered, and a result still waiting on the output holds the next one in its last step.
// Reset, and every write to either configuration register, start a clearing pass over the
// block table, during which no request is accepted.
module linked_block_chain_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = 256,
  parameter int unsigned NUM_SLOTS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [lbca_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lbca_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lbca_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [lbca_pkg::SLOT_W-1:0]      file_slot_i,
  input  logic [lbca_pkg::COUNT_W-1:0]     block_count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [lbca_pkg::STATUS_W-1:0]    status_o,
  output logic [lbca_pkg::FIRST_W-1:0]     first_block_o,
  output logic [lbca_pkg::COUNT_W-1:0]     blocks_moved_o,
  output logic [lbca_pkg::COUNT_W-1:0]     free_left_o
);

  localparam int unsigned BW = $clog2(NUM_BLOCKS);

  logic [lbca_pkg::CFG_DATA_W-1:0]  blocks_q, blocks_d;
  logic [lbca_pkg::SLOTS_REG_W-1:0] slots_q, slots_d;
  logic                             clear_req;
  lbca_pkg::mem_ctl_t               mem_ctl;
  logic [BW-1:0]                    rd_addr;
  logic [BW-1:0]                    used_addr;
  logic [BW-1:0]                    next_addr;
  logic [BW-1:0]                    next_data;
  logic                             used_rd;
  logic [BW-1:0]                    next_rd;

  // Configuration registers; a write to either one clears the tables.
  always_comb begin
    blocks_d  = blocks_q;
    slots_d   = slots_q;
    clear_req = 1'b0;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        lbca_pkg::CFG_BLOCKS_IN_USE: begin
          blocks_d  = cfg_data_i;
          clear_req = 1'b1;
        end
        lbca_pkg::CFG_SLOTS_IN_USE: begin
          slots_d   = cfg_data_i[lbca_pkg::SLOTS_REG_W-1:0];
          clear_req = 1'b1;
        end
        default: begin
          clear_req = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= lbca_pkg::BLOCKS_RESET;
      slots_q  <= lbca_pkg::SLOTS_RESET;
    end else begin
      blocks_q <= blocks_d;
      slots_q  <= slots_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  lbca_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .NUM_SLOTS  (NUM_SLOTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_req_i     (clear_req),
    .blocks_in_use_i (blocks_q),
    .slots_in_use_i  (slots_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .file_slot_i     (file_slot_i),
    .block_count_i   (block_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .first_block_o   (first_block_o),
    .blocks_moved_o  (blocks_moved_o),
    .free_left_o     (free_left_o),
    .mem_ctl_o       (mem_ctl),
    .rd_addr_o       (rd_addr),
    .used_addr_o     (used_addr),
    .next_addr_o     (next_addr),
    .next_data_o     (next_data),
    .used_rd_i       (used_rd),
    .next_rd_i       (next_rd)
  );

  // Block table.
  lbca_mem #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_mem (
    .clk_i       (clk_i),
    .ctl_i       (mem_ctl),
    .rd_addr_i   (rd_addr),
    .used_addr_i (used_addr),
    .next_addr_i (next_addr),
    .next_data_i (next_data),
    .used_rd_o   (used_rd),
    .next_rd_o   (next_rd)
  );

endmodule

// File: src/lbca_checker.sv
// Port-level checks of the allocator and the bind that attaches them.
// Watches the top level's request and result channels; uses lbca_pkg.
module lbca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [lbca_pkg::STATUS_W-1:0] status_i,
  input logic [lbca_pkg::FIRST_W-1:0]  first_block_i,
  input logic [lbca_pkg::COUNT_W-1:0]  blocks_moved_i,
  input logic [lbca_pkg::COUNT_W-1:0]  free_left_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(first_block_i) &&
      $stable(blocks_moved_i) && $stable(free_left_i))
    else $error("result payload changed while stalled");

  // One request at a time: accepting one closes the input side.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while another is in work");

  // A failed request reports no chain.
  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != lbca_pkg::ST_OK) |-> (first_block_i == '0) &&
      (blocks_moved_i == '0))
    else $error("failed request reports a chain");

  // A successful request always moves at least one block.
  a_ok_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == lbca_pkg::ST_OK) |-> (blocks_moved_i != '0))
    else $error("successful request moved no block");

endmodule

bind linked_block_chain_allocator_unit lbca_checker u_lbca_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_i       (status_o),
  .first_block_i  (first_block_o),
  .blocks_moved_i (blocks_moved_o),
  .free_left_i    (free_left_o)
);

// File: tb/chain_table_checker.sv
`timescale 1ns / 1ps
// Checker for the linked block chain allocator: it follows register writes and requests on
// the ports, predicts each result and compares it with the next result the block hands out.
// Depends on lbca_pkg for widths, register indexes, opcodes and status codes.
module chain_table_checker #(
  parameter int unsigned NUM_BLOCKS = 256,
  parameter int unsigned NUM_SLOTS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [lbca_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lbca_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [lbca_pkg::OPCODE_W-1:0]    opcode_i,
  input  logic [lbca_pkg::SLOT_W-1:0]      file_slot_i,
  input  logic [lbca_pkg::COUNT_W-1:0]     block_count_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [lbca_pkg::STATUS_W-1:0]    status_i,
  input  logic [lbca_pkg::FIRST_W-1:0]     first_block_i,
  input  logic [lbca_pkg::COUNT_W-1:0]     blocks_moved_i,
  input  logic [lbca_pkg::COUNT_W-1:0]     free_left_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      checked_o
);

  import lbca_pkg::*;

  typedef struct packed {
    status_e              status;
    logic [FIRST_W-1:0]   first_block;
    logic [COUNT_W-1:0]   blocks_moved;
    logic [COUNT_W-1:0]   free_left;
  } chain_result_t;

  // Predicted block table and slot table.
  bit          used_map   [NUM_BLOCKS];
  int unsigned next_map   [NUM_BLOCKS];
  bit          slot_live  [NUM_SLOTS];
  int unsigned slot_first [NUM_SLOTS];
  int unsigned blocks_free;
  int unsigned block_limit;
  int unsigned slot_limit;

  chain_result_t expected_results[$];
  int unsigned   fails;
  int unsigned   checked;

  function automatic int unsigned clip(input int unsigned value, input int unsigned hi);
    return (value < hi) ? value : hi;
  endfunction

  // A write to either register frees every block and empties every slot.
  task automatic reinit_tables();
    for (int unsigned b = 0; b < NUM_BLOCKS; b++) begin
      used_map[b] = 1'b0;
      next_map[b] = 0;
    end
    for (int unsigned s = 0; s < NUM_SLOTS; s++) begin
      slot_live[s]  = 1'b0;
      slot_first[s] = 0;
    end
    blocks_free = block_limit;
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_BLOCKS_IN_USE: begin
        block_limit = clip(data, NUM_BLOCKS);
        reinit_tables();
      end
      CFG_SLOTS_IN_USE: begin
        slot_limit = clip(data[SLOTS_REG_W-1:0], NUM_SLOTS);
        reinit_tables();
      end
      default: begin
        // Indexes past the register list are ignored.
      end
    endcase
  endtask

  // Works out the result of one request and updates the predicted tables.
  task automatic predict_request(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
                                 input logic [COUNT_W-1:0] want, output chain_result_t res);
    int unsigned got;
    int unsigned head;
    int unsigned prev;
    int unsigned cur;
    int unsigned nxt;
    int unsigned moved;
    res.status       = ST_OK;
    res.first_block  = '0;
    res.blocks_moved = '0;
    if (slot >= slot_limit) begin
      res.status = ST_SLOT_BUSY;
    end else if (op == OP_ALLOC) begin
      if (slot_live[slot]) begin
        res.status = ST_SLOT_BUSY;
      end else if (want == 0) begin
        res.status = ST_ZERO_COUNT;
      end else if (want > blocks_free) begin
        res.status = ST_NO_SPACE;
      end else begin
        // First fit: claim the lowest free blocks and link them in ascending order.
        got  = 0;
        head = 0;
        prev = 0;
        for (int unsigned b = 0; b < block_limit && got < want; b++) begin
          if (!used_map[b]) begin
            used_map[b] = 1'b1;
            if (got == 0) head = b;
            else next_map[prev] = b;
            prev = b;
            got++;
          end
        end
        // The tail of the chain links to itself.
        next_map[prev]   = prev;
        slot_live[slot]  = 1'b1;
        slot_first[slot] = head;
        blocks_free      = blocks_free - got;
        res.first_block  = head[FIRST_W-1:0];
        res.blocks_moved = got[COUNT_W-1:0];
      end
    end else begin
      if (!slot_live[slot]) begin
        res.status = ST_SLOT_EMPTY;
      end else begin
        // Walk the chain until a block links to itself, counting each block once.
        head  = slot_first[slot] % NUM_BLOCKS;
        cur   = head;
        moved = 0;
        for (int unsigned hop = 0; hop < NUM_BLOCKS; hop++) begin
          nxt = next_map[cur] % NUM_BLOCKS;
          if (used_map[cur]) begin
            used_map[cur] = 1'b0;
            moved++;
          end
          if (nxt == cur) break;
          cur = nxt;
        end
        slot_live[slot]  = 1'b0;
        blocks_free      = blocks_free + moved;
        res.first_block  = head[FIRST_W-1:0];
        res.blocks_moved = moved[COUNT_W-1:0];
      end
    end
    res.free_left = blocks_free[COUNT_W-1:0];
  endtask

  // Results are compared before new requests are predicted, since a result always
  // belongs to an earlier request.
  always @(posedge clk_i or negedge rst_ni) begin
    chain_result_t oldest;
    chain_result_t fresh;
    if (!rst_ni) begin
      block_limit = clip(BLOCKS_RESET, NUM_BLOCKS);
      slot_limit  = clip(SLOTS_RESET, NUM_SLOTS);
      reinit_tables();
      expected_results.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("Mismatch: unexpected result status %0d first %0d moved %0d left %0d",
                     status_i, first_block_i, blocks_moved_i, free_left_i);
        end else begin
          oldest = expected_results.pop_front();
          checked++;
          if (status_i !== oldest.status || first_block_i !== oldest.first_block ||
              blocks_moved_i !== oldest.blocks_moved || free_left_i !== oldest.free_left) begin
            fails++;
            if (fails <= 10)
              $display({"Mismatch on result %0d (expected/actual): status %0d/%0d ",
                        "first %0d/%0d moved %0d/%0d left %0d/%0d"}, checked,
                       oldest.status, status_i, oldest.first_block, first_block_i,
                       oldest.blocks_moved, blocks_moved_i, oldest.free_left, free_left_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        predict_request(opcode_i, file_slot_i, block_count_i, fresh);
        expected_results.push_back(fresh);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
    checked_o    <= checked;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request and register stimulus, result stalls,
// watchdog and verdict. Depends on lbca_pkg, the allocator unit and chain_table_checker.
module tb;

  import lbca_pkg::*;

  localparam int unsigned NUM_BLOCKS      = 256;
  localparam int unsigned NUM_SLOTS       = 16;
  localparam int unsigned HOLD_CYCLES     = 1000;
  localparam int unsigned QUIET_LIMIT     = 20000;
  localparam int unsigned TAIL_CYCLES     = 300;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 122;

  // Register indexes past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic [OPCODE_W-1:0]    opcode_i      = OP_ALLOC;
  logic [SLOT_W-1:0]      file_slot_i   = '0;
  logic [COUNT_W-1:0]     block_count_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [STATUS_W-1:0]    status_o;
  logic [FIRST_W-1:0]     first_block_o;
  logic [COUNT_W-1:0]     blocks_moved_o;
  logic [COUNT_W-1:0]     free_left_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned compared;

  // Light view of the tables, used only to steer requests toward ones that succeed.
  int unsigned lim_blocks;
  int unsigned lim_slots;
  int unsigned free_est;
  bit          slot_taken [NUM_SLOTS];
  int unsigned slot_size  [NUM_SLOTS];

  bit          gaps_on;
  int unsigned requests_sent = 0;
  int unsigned reg_writes    = 0;
  int unsigned quiet_cycles  = 0;

  linked_block_chain_allocator_unit #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .NUM_SLOTS (NUM_SLOTS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .file_slot_i   (file_slot_i),
    .block_count_i (block_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .first_block_o (first_block_o),
    .blocks_moved_o(blocks_moved_o),
    .free_left_o   (free_left_o)
  );

  chain_table_checker #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .NUM_SLOTS (NUM_SLOTS)
  ) u_chain_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .opcode_i      (opcode_i),
    .file_slot_i   (file_slot_i),
    .block_count_i (block_count_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .first_block_i (first_block_o),
    .blocks_moved_i(blocks_moved_o),
    .free_left_i   (free_left_o),
    .fail_count_o  (mismatches),
    .pending_o     (outstanding),
    .checked_o     (compared)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void clear_tracker();
    free_est = lim_blocks;
    for (int unsigned s = 0; s < NUM_SLOTS; s++) slot_taken[s] = 1'b0;
  endfunction

  function automatic void track_request(input logic [OPCODE_W-1:0] op,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic [COUNT_W-1:0] cnt);
    if (slot < lim_slots) begin
      if (op == OP_ALLOC) begin
        if (!slot_taken[slot] && cnt != 0 && cnt <= free_est) begin
          slot_taken[slot] = 1'b1;
          slot_size[slot]  = cnt;
          free_est         = free_est - cnt;
        end
      end else if (slot_taken[slot]) begin
        slot_taken[slot] = 1'b0;
        free_est         = free_est + slot_size[slot];
      end
    end
  endfunction

  // Offers one request after an optional gap and waits until it is taken.
  task automatic offer(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
                       input logic [COUNT_W-1:0] cnt);
    int unsigned gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= op;
    file_slot_i   <= slot;
    block_count_i <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    track_request(op, slot, cnt);
    requests_sent++;
  endtask

  // Register write; the caller drops the valid once its writes are done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    reg_writes++;
    if (idx == CFG_BLOCKS_IN_USE) begin
      lim_blocks = (data > NUM_BLOCKS) ? NUM_BLOCKS : data;
      clear_tracker();
    end else if (idx == CFG_SLOTS_IN_USE) begin
      lim_slots = (data[SLOTS_REG_W-1:0] > NUM_SLOTS) ? NUM_SLOTS : data[SLOTS_REG_W-1:0];
      clear_tracker();
    end
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] blocks, input logic [CFG_DATA_W-1:0] slots);
    wait_idle();
    write_reg(CFG_BLOCKS_IN_USE, blocks);
    write_reg(CFG_SLOTS_IN_USE, slots);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed requests on the current tables, the rest random noise.
  task automatic make_request(output logic [OPCODE_W-1:0] op, output logic [SLOT_W-1:0] slot,
                              output logic [COUNT_W-1:0] cnt);
    int unsigned pick;
    int unsigned start;
    int unsigned cap;
    int unsigned s;
    bit have_free;
    bit have_busy;
    have_free = 1'b0;
    have_busy = 1'b0;
    for (int unsigned k = 0; k < lim_slots; k++) begin
      if (slot_taken[k]) have_busy = 1'b1;
      else have_free = 1'b1;
    end
    op   = OP_FREE;
    slot = '0;
    cnt  = '0;
    if ($urandom_range(99) < 15 || (!have_free && !have_busy)) begin
      op   = OPCODE_W'($urandom_range(1));
      slot = SLOT_W'($urandom_range(NUM_SLOTS - 1));
      pick = $urandom_range(2);
      if (pick == 0) cnt = '0;
      else if (pick == 1) cnt = COUNT_W'($urandom_range(511));
      else cnt = COUNT_W'($urandom_range(8, 1));
    end else if (have_busy && (!have_free || free_est == 0 || $urandom_range(99) < 45)) begin
      op    = OP_FREE;
      start = $urandom_range(lim_slots - 1);
      for (int unsigned k = 0; k < lim_slots; k++) begin
        s = (start + k) % lim_slots;
        if (slot_taken[s]) begin
          slot = SLOT_W'(s);
          break;
        end
      end
    end else begin
      op    = OP_ALLOC;
      start = $urandom_range(lim_slots - 1);
      for (int unsigned k = 0; k < lim_slots; k++) begin
        s = (start + k) % lim_slots;
        if (!slot_taken[s]) begin
          slot = SLOT_W'(s);
          break;
        end
      end
      // Small chains most of the time, now and then the whole free space.
      cap = (lim_blocks / 8 == 0) ? 1 : lim_blocks / 8;
      if (cap > free_est) cap = free_est;
      pick = $urandom_range(9);
      if (free_est == 0) cnt = COUNT_W'(1);
      else if (pick < 7) cnt = COUNT_W'($urandom_range(cap, 1));
      else if (pick < 9) cnt = COUNT_W'($urandom_range(free_est, 1));
      else cnt = COUNT_W'(free_est);
    end
  endtask

  // Result side: random stalls with stall-free stretches, plus two long hold-offs
  // that leave the sender blocked behind a full block.
  initial begin : result_stalls
    int unsigned results_taken;
    int unsigned stall;
    int unsigned mode;
    bit held_once;
    bit held_twice;
    results_taken = 0;
    held_once     = 1'b0;
    held_twice    = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) results_taken++;
      mode = (results_taken / 64) % 3;
      if ((results_taken >= 150 && !held_once) || (results_taken >= 700 && !held_twice)) begin
        if (held_once) held_twice = 1'b1;
        else held_once = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (mode != 0 && $urandom_range(99) < ((mode == 1) ? 30 : 10)) begin
        stall = gap_len() + 1;
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Ends the run when no channel has moved for too long.
  always @(posedge clk_i) begin
    if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
        (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [OPCODE_W-1:0]   op;
    logic [SLOT_W-1:0]     slot;
    logic [COUNT_W-1:0]    cnt;
    logic [CFG_DATA_W-1:0] blocks;
    logic [CFG_DATA_W-1:0] slots;
    lim_blocks = NUM_BLOCKS;
    lim_slots  = NUM_SLOTS;
    clear_tracker();
    gaps_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the reset configuration.
    offer(OP_ALLOC, 4'd0, 9'd0);      // zero count
    offer(OP_FREE, 4'd0, 9'd0);       // free of an empty slot
    offer(OP_ALLOC, 4'd0, 9'd1);      // chain of a single block
    offer(OP_ALLOC, 4'd0, 9'd3);      // slot already holds a chain
    offer(OP_ALLOC, 4'd1, 9'd256);    // one block short
    offer(OP_ALLOC, 4'd1, 9'd511);    // count far beyond the table
    offer(OP_ALLOC, 4'd1, 9'd5);
    offer(OP_ALLOC, 4'd15, 9'd250);   // takes every remaining block
    offer(OP_ALLOC, 4'd2, 9'd1);      // table full
    offer(OP_FREE, 4'd0, 9'd0);       // single block counted once
    offer(OP_FREE, 4'd1, 9'd0);
    offer(OP_ALLOC, 4'd2, 9'd6);
    offer(OP_FREE, 4'd15, 9'd0);
    offer(OP_FREE, 4'd2, 9'd0);
    offer(OP_ALLOC, 4'd3, 9'd256);    // whole table in one chain
    offer(OP_FREE, 4'd3, 9'd511);

    // No usable slot: upper data bits set, low bits zero.
    configure(9'd256, 9'h1E0);
    offer(OP_ALLOC, 4'd0, 9'd1);
    offer(OP_ALLOC, 4'd0, 9'd0);      // range check wins over zero count
    offer(OP_FREE, 4'd0, 9'd0);
    offer(OP_ALLOC, 4'd15, 9'd1);

    // No usable block, slot count saturating.
    configure(9'd0, 9'h01F);
    offer(OP_ALLOC, 4'd15, 9'd1);
    offer(OP_ALLOC, 4'd3, 9'd0);
    offer(OP_FREE, 4'd15, 9'd0);

    // Random phases, each under its own register settings.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin blocks = 9'd256; slots = 9'd16;  end
        1: begin blocks = 9'd1;   slots = 9'd1;   end
        2: begin blocks = 9'd2;   slots = 9'd2;   end
        3: begin blocks = 9'd300; slots = 9'h01F; end
        4: begin blocks = 9'h1FF; slots = 9'h1F0; end
        5: begin
          blocks = CFG_DATA_W'($urandom_range(256, 1));
          slots  = CFG_DATA_W'($urandom_range(16, 1));
        end
        6: begin blocks = 9'd16;  slots = 9'd4;   end
        7: begin blocks = 9'd64;  slots = 9'h0AF; end
        default: begin blocks = 9'd200; slots = 9'd9; end
      endcase
      configure(blocks, slots);
      gaps_on = ph[0];
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2 && ph == 4) wait_idle();
        // Writes to unused indexes must leave the live tables alone.
        if (n == ITEMS_PER_PHASE / 2 && ph == 5) begin
          wait_idle();
          write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom_range(511)));
          write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom_range(511)));
          cfg_valid_i <= 1'b0;
        end
        make_request(op, slot, cnt);
        offer(op, slot, cnt);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Run covered %0d requests, %0d register writes and %0d compared results,",
             requests_sent, reg_writes, compared);
    $display("with tables from empty to full, saturated registers and long result stalls.");
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
